@@ design/umi_whitelist_matcher_macros.svh @@
// Assertion helpers for the UMI whitelist matcher.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef UMI_WHITELIST_MATCHER_MACROS_SVH
`define UMI_WHITELIST_MATCHER_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define UWM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define UWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/uwm_pkg.sv @@
package uwm_pkg;

    // Payload widths fixed by the interface.
    localparam int BASES_W       = 64;
    localparam int BYTES_PER_UMI = BASES_W / 8;
    localparam int DIST_W        = 4;
    localparam int ENTRY_INDEX_W = 5;
    localparam int MATCH_INDEX_W = 5;

    // Configuration register file.
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 6;
    localparam int CMP_LEN_W       = 4;
    localparam int CODEWORD_COUNT_W = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_CMP_LEN        = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CODEWORD_COUNT = 1'd1;

    localparam logic [CMP_LEN_W-1:0]        CMP_LEN_RESET        = 4'd8;
    localparam logic [CODEWORD_COUNT_W-1:0] CODEWORD_COUNT_RESET = 6'd0;

    // Request kinds.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_MATCH = 1'b1;

    // Acceptance rule: best distance at most one, and a single error only
    // when the runner-up is at least three away.
    localparam logic [DIST_W-1:0] ACCEPT_MAX_BEST   = 4'd1;
    localparam logic [DIST_W-1:0] UNIQUE_MIN_RUNNER = 4'd3;

endpackage

@@ design/umi_whitelist_matcher.sv @@
// UMI whitelist matcher: load requests (mode 0) write one 64-bit codeword into
// a whitelist slot and produce no result; match requests (mode 1) compare the
// configured number of leading bytes of read_bases against every entry below
// codeword_count in parallel and return the best and runner-up Hamming
// distances, the first entry at the best distance and its masked bases, and
// whether the read is accepted (best 0, or best 1 with runner-up 3 or more).
// A new request is taken every cycle unless in_stall is raised. A match
// result passes through the registered per-entry distance compare, each
// level of the registered min-reduction tree, and the output register.
// Bubbles collapse, so a stalled output only holds back stages that are full.
// Configuration writes must only happen while no match is in flight.
`include "umi_whitelist_matcher_macros.svh"

module umi_whitelist_matcher #(
    parameter int MAX_CODEWORDS = 32,
    parameter int MAX_CMP_LEN   = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_write,
    input  logic [uwm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [uwm_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Request channel.
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic [uwm_pkg::ENTRY_INDEX_W-1:0]    entry_index,
    input  logic [uwm_pkg::BASES_W-1:0]          entry_bases,
    input  logic [uwm_pkg::BASES_W-1:0]          read_bases,
    // Result channel.
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 accepted,
    output logic [uwm_pkg::MATCH_INDEX_W-1:0]    match_index,
    output logic [uwm_pkg::BASES_W-1:0]          corrected_umi,
    output logic [uwm_pkg::DIST_W-1:0]           best_distance,
    output logic [uwm_pkg::DIST_W-1:0]           runner_up_distance
);

    import uwm_pkg::*;

    localparam int LEVELS = (MAX_CODEWORDS > 1) ? $clog2(MAX_CODEWORDS) : 0;
    localparam int LEAVES = 1 << LEVELS;
    localparam int IDX_W  = (MAX_CODEWORDS > 1) ? $clog2(MAX_CODEWORDS) : 1;
    localparam logic [CMP_LEN_W-1:0] MAX_LEN = CMP_LEN_W'(MAX_CMP_LEN);

    // One node of the reduction tree: the two smallest distances of its
    // subtree, the first entry at the smallest and that entry's bases.
    typedef struct packed {
        logic [DIST_W-1:0]  best;
        logic [DIST_W-1:0]  runner;
        logic [IDX_W-1:0]   idx;
        logic [BASES_W-1:0] bases;
    } node_t;

    // Merge two subtrees; the lower-indexed side wins ties.
    function automatic node_t merge_nodes(node_t lo, node_t hi);
        node_t              res;
        logic [DIST_W-1:0]  larger_best;
        logic [DIST_W-1:0]  smaller_runner;
        larger_best    = (lo.best <= hi.best) ? hi.best : lo.best;
        smaller_runner = (lo.runner <= hi.runner) ? lo.runner : hi.runner;
        if (lo.best <= hi.best)
        begin
            res = lo;
        end
        else
        begin
            res = hi;
        end
        res.runner = (larger_best <= smaller_runner) ? larger_best : smaller_runner;
        return res;
    endfunction

    // Configuration registers.
    logic [CMP_LEN_W-1:0]        cmp_len_reg;
    logic [CODEWORD_COUNT_W-1:0] codeword_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_len_reg        <= CMP_LEN_RESET;
            codeword_count_reg <= CODEWORD_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CMP_LEN:        cmp_len_reg        <= cfg_data[CMP_LEN_W-1:0];
                REG_CODEWORD_COUNT: codeword_count_reg <= cfg_data[CODEWORD_COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Length clamped to the supported range.
    logic [CMP_LEN_W-1:0] eff_len;

    always_comb
    begin
        if (cmp_len_reg == '0)
        begin
            eff_len = CMP_LEN_W'(1);
        end
        else if (cmp_len_reg > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = cmp_len_reg;
        end
    end

    // Stage enables: a stage moves when it is empty or the next one moves.
    logic [LEVELS:0] stage_valid_reg;
    logic [LEVELS:0] stage_en;
    logic            out_valid_reg;
    logic            out_en;

    assign out_en = !out_valid_reg || !out_stall;

    always_comb
    begin
        stage_en[LEVELS] = !stage_valid_reg[LEVELS] || out_en;
        for (int k = LEVELS - 1; k >= 0; k--)
        begin
            stage_en[k] = !stage_valid_reg[k] || stage_en[k + 1];
        end
    end

    logic in_accept;

    assign in_stall  = !stage_en[0];
    assign in_accept = in_valid && stage_en[0];

    // Whitelist storage, one row per entry.
    logic [BASES_W-1:0] whitelist_reg [MAX_CODEWORDS];

    always_ff @(posedge clk)
    begin
        if (in_accept && (mode == MODE_LOAD) && (32'(entry_index) < MAX_CODEWORDS))
        begin
            whitelist_reg[IDX_W'(entry_index)] <= entry_bases;
        end
    end

    // Byte mask for the compared length.
    logic [BASES_W-1:0] len_mask;

    always_comb
    begin
        for (int k = 0; k < BYTES_PER_UMI; k++)
        begin
            len_mask[8*k +: 8] = (CMP_LEN_W'(k) < eff_len) ? 8'hFF : 8'h00;
        end
    end

    // Tree nodes in heap order: root at 1, leaves from LEAVES upward.
    node_t node_reg [1:2*LEAVES-1];
    node_t leaf_next [LEAVES];

    // Per-entry distance compare at request acceptance.
    for (genvar j = 0; j < LEAVES; j++)
    begin : g_leaf
        if (j < MAX_CODEWORDS)
        begin : g_live
            always_comb
            begin
                logic [DIST_W-1:0] byte_diffs;
                byte_diffs = '0;
                for (int k = 0; k < BYTES_PER_UMI; k++)
                begin
                    if ((CMP_LEN_W'(k) < eff_len) &&
                        (read_bases[8*k +: 8] != whitelist_reg[j][8*k +: 8]))
                    begin
                        byte_diffs = byte_diffs + DIST_W'(1);
                    end
                end
                leaf_next[j].idx    = IDX_W'(j);
                leaf_next[j].bases  = whitelist_reg[j] & len_mask;
                leaf_next[j].runner = DIST_W'(eff_len);
                if (32'(codeword_count_reg) > j)
                begin
                    leaf_next[j].best = byte_diffs;
                end
                else
                begin
                    leaf_next[j].best = DIST_W'(eff_len);
                end
            end
        end
        else
        begin : g_pad
            always_comb
            begin
                leaf_next[j].idx    = IDX_W'(j);
                leaf_next[j].bases  = '0;
                leaf_next[j].runner = DIST_W'(eff_len);
                leaf_next[j].best   = DIST_W'(eff_len);
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[0])
            begin
                node_reg[LEAVES + j] <= leaf_next[j];
            end
        end
    end

    // Registered reduction levels.
    for (genvar i = 1; i < LEAVES; i++)
    begin : g_node
        localparam int LVL = LEVELS - ($clog2(i + 1) - 1);
        always_ff @(posedge clk)
        begin
            if (stage_en[LVL])
            begin
                node_reg[i] <= merge_nodes(node_reg[2*i], node_reg[2*i + 1]);
            end
        end
    end

    // Valid bits travel with the tree levels.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                stage_valid_reg[0] <= in_valid && (mode == MODE_MATCH);
            end
            for (int k = 1; k <= LEVELS; k++)
            begin
                if (stage_en[k])
                begin
                    stage_valid_reg[k] <= stage_valid_reg[k - 1];
                end
            end
        end
    end

    // Acceptance decision on the root.
    node_t                     root;
    logic                      accepted_next;
    logic [MATCH_INDEX_W-1:0]  match_index_next;
    logic [BASES_W-1:0]        corrected_umi_next;

    assign root = node_reg[1];

    always_comb
    begin
        accepted_next = (root.best < DIST_W'(eff_len)) &&
                        ((root.best < ACCEPT_MAX_BEST) ||
                         ((root.best == ACCEPT_MAX_BEST) &&
                          (root.runner >= UNIQUE_MIN_RUNNER)));
        match_index_next   = accepted_next ? MATCH_INDEX_W'(root.idx) : '0;
        corrected_umi_next = accepted_next ? root.bases : '0;
    end

    // Output register.
    logic                      accepted_reg;
    logic [MATCH_INDEX_W-1:0]  match_index_reg;
    logic [BASES_W-1:0]        corrected_umi_reg;
    logic [DIST_W-1:0]         best_distance_reg;
    logic [DIST_W-1:0]         runner_up_distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= stage_valid_reg[LEVELS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            accepted_reg           <= accepted_next;
            match_index_reg        <= match_index_next;
            corrected_umi_reg      <= corrected_umi_next;
            best_distance_reg      <= root.best;
            runner_up_distance_reg <= root.runner;
        end
    end

    assign out_valid          = out_valid_reg;
    assign accepted           = accepted_reg;
    assign match_index        = match_index_reg;
    assign corrected_umi      = corrected_umi_reg;
    assign best_distance      = best_distance_reg;
    assign runner_up_distance = runner_up_distance_reg;

    // Checks on the reduction and the acceptance rule.
    `UWM_ASSERT_IMP(a_order, out_valid, best_distance <= runner_up_distance,
                    "runner-up below best")
    `UWM_ASSERT_IMP(a_accept_best, out_valid && accepted,
                    best_distance <= ACCEPT_MAX_BEST, "accepted with large distance")
    `UWM_ASSERT_IMP(a_accept_unique,
                    out_valid && accepted && (best_distance == ACCEPT_MAX_BEST),
                    runner_up_distance >= UNIQUE_MIN_RUNNER, "accepted ambiguous correction")
    `UWM_ASSERT_IMP(a_reject_zero, out_valid && !accepted,
                    (match_index == '0) && (corrected_umi == '0),
                    "rejected read carries an entry")

endmodule

@@ sim/tb_umi_whitelist_matcher.sv @@
`timescale 1ns / 100ps

module tb_umi_whitelist_matcher;
    import uwm_pkg::*;

    localparam int NUM_SLOTS     = 32;
    localparam int MAX_LEN       = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_PRINTS    = 100;
    localparam int SEGMENT_ITEMS = 200;
    localparam int HOLD_CYCLES   = 200;

    typedef struct packed {
        logic                     mode;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [BASES_W-1:0]       entry_bases;
        logic [BASES_W-1:0]       read_bases;
    } umi_request_t;

    typedef struct packed {
        logic                     accepted;
        logic [MATCH_INDEX_W-1:0] match_index;
        logic [BASES_W-1:0]       corrected_umi;
        logic [DIST_W-1:0]        best_distance;
        logic [DIST_W-1:0]        runner_up_distance;
    } umi_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     mode = 1'b0;
    logic [ENTRY_INDEX_W-1:0] entry_index = '0;
    logic [BASES_W-1:0]       entry_bases = '0;
    logic [BASES_W-1:0]       read_bases = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     accepted;
    logic [MATCH_INDEX_W-1:0] match_index;
    logic [BASES_W-1:0]       corrected_umi;
    logic [DIST_W-1:0]        best_distance;
    logic [DIST_W-1:0]        runner_up_distance;

    // Predictor state: whitelist and register copies as the block sees them.
    logic [BASES_W-1:0]          model_words [NUM_SLOTS];
    logic [CMP_LEN_W-1:0]        model_len = CMP_LEN_RESET;
    logic [CODEWORD_COUNT_W-1:0] model_count = CODEWORD_COUNT_RESET;

    // Whitelist as it will be once every queued request has been taken.
    logic [BASES_W-1:0] planned_words [NUM_SLOTS];

    umi_request_t pending_requests [$];
    umi_result_t  expected_matches [$];
    umi_request_t presented;

    int requests_queued = 0;
    int requests_taken  = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    logic out_hold      = 1'b0;

    umi_whitelist_matcher dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .mode               (mode),
        .entry_index        (entry_index),
        .entry_bases        (entry_bases),
        .read_bases         (read_bases),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .accepted           (accepted),
        .match_index        (match_index),
        .corrected_umi      (corrected_umi),
        .best_distance      (best_distance),
        .runner_up_distance (runner_up_distance)
    );

    always #6 clk = ~clk;

    // Length and count as the block clamps them.
    function automatic int eff_length();
        int n;
        n = int'(model_len);
        if (n < 1)
            n = 1;
        if (n > MAX_LEN)
            n = MAX_LEN;
        return n;
    endfunction

    function automatic int eff_count();
        return (model_count > NUM_SLOTS) ? NUM_SLOTS : int'(model_count);
    endfunction

    function automatic logic [BASES_W-1:0] length_mask(int len);
        if (len >= MAX_LEN)
            return '1;
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    // Best and runner-up byte distance over all valid entries.
    function automatic umi_result_t predict_match(logic [BASES_W-1:0] read);
        umi_result_t r;
        int len;
        int cnt;
        int best;
        int runner;
        int best_idx;
        int diffs;
        bit found;
        bit ok;
        len = eff_length();
        cnt = eff_count();
        best = len;
        runner = len;
        best_idx = 0;
        found = 1'b0;
        for (int j = 0; j < cnt; j++)
        begin
            diffs = 0;
            for (int k = 0; k < len; k++)
                if (read[8*k +: 8] != model_words[j][8*k +: 8])
                    diffs++;
            if (diffs < best)
            begin
                runner = best;
                best = diffs;
                best_idx = j;
                found = 1'b1;
            end
            else if (diffs < runner)
            begin
                runner = diffs;
            end
        end
        ok = found && !(best > ACCEPT_MAX_BEST ||
                        (best == ACCEPT_MAX_BEST && runner < UNIQUE_MIN_RUNNER));
        r.accepted = ok;
        r.match_index = ok ? MATCH_INDEX_W'(best_idx) : '0;
        r.corrected_umi = ok ? (model_words[best_idx] & length_mask(len)) : '0;
        r.best_distance = DIST_W'(best);
        r.runner_up_distance = DIST_W'(runner);
        return r;
    endfunction

    function automatic void apply_request(umi_request_t req);
        if (req.mode == MODE_LOAD)
            model_words[req.entry_index] = req.entry_bases;
        else
            expected_matches.push_back(predict_match(req.read_bases));
    endfunction

    task automatic report_mismatch(string what, logic [BASES_W-1:0] got,
                                   logic [BASES_W-1:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t: mismatch on %s: got %h, expected %h",
                     $time, what, got, want);
    endtask

    // Stimulus helpers. Bases are ASCII, first base in the low byte.
    function automatic logic [BASES_W-1:0] to_bases(string s);
        logic [BASES_W-1:0] w;
        w = '0;
        for (int k = 0; k < s.len() && k < MAX_LEN; k++)
            w[8*k +: 8] = s[k];
        return w;
    endfunction

    function automatic logic [BASES_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [BASES_W-1:0] random_codeword();
        logic [BASES_W-1:0] w;
        for (int k = 0; k < MAX_LEN; k++)
        begin
            case ($urandom_range(3))
                0: w[8*k +: 8] = "A";
                1: w[8*k +: 8] = "C";
                2: w[8*k +: 8] = "G";
                default: w[8*k +: 8] = "T";
            endcase
        end
        return w;
    endfunction

    function automatic logic [BASES_W-1:0] with_errors(logic [BASES_W-1:0] w, int errors,
                                                       int len);
        int pos;
        for (int e = 0; e < errors; e++)
        begin
            pos = $urandom_range(len - 1);
            w[8*pos +: 8] = w[8*pos +: 8] ^ 8'($urandom_range(255, 1));
        end
        return w;
    endfunction

    function automatic void queue_load(int slot, logic [BASES_W-1:0] bases);
        umi_request_t req;
        req.mode = MODE_LOAD;
        req.entry_index = ENTRY_INDEX_W'(slot);
        req.entry_bases = bases;
        req.read_bases = random_word();
        pending_requests.push_back(req);
        planned_words[slot] = bases;
        requests_queued++;
    endfunction

    function automatic void queue_match(logic [BASES_W-1:0] read);
        umi_request_t req;
        req.mode = MODE_MATCH;
        req.entry_index = ENTRY_INDEX_W'($urandom());
        req.entry_bases = random_word();
        req.read_bases = read;
        pending_requests.push_back(req);
        requests_queued++;
    endfunction

    // Mostly reads taken from the whitelist with zero to two base errors.
    function automatic void queue_random_match();
        int len;
        int cnt;
        int sel;
        logic [BASES_W-1:0] w;
        len = eff_length();
        cnt = eff_count();
        sel = $urandom_range(99);
        if (cnt == 0 || sel >= 90)
        begin
            w = (sel >= 95) ? random_word() : random_codeword();
        end
        else
        begin
            w = planned_words[$urandom_range(cnt - 1)];
            if (sel >= 55)
                w = with_errors(w, 1, len);
            if (sel >= 80)
                w = with_errors(w, 1, len);
        end
        // Bases past the compared length must not matter.
        if (len < MAX_LEN && $urandom_range(1) == 1)
            w = (w & length_mask(len)) | (random_word() & ~length_mask(len));
        queue_match(w);
    endfunction

    // Reloads that often land close to, or on top of, another entry.
    function automatic void queue_random_load();
        int sel;
        logic [BASES_W-1:0] other;
        sel = $urandom_range(99);
        other = planned_words[$urandom_range(NUM_SLOTS - 1)];
        if (sel < 40)
            other = with_errors(other, $urandom_range(2, 1), eff_length());
        else if (sel >= 50 && sel < 90)
            other = random_codeword();
        else if (sel >= 90)
            other = random_word();
        queue_load($urandom_range(NUM_SLOTS - 1), other);
    endfunction

    function automatic void queue_segment(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 15)
                queue_random_load();
            else
                queue_random_match();
        end
    endfunction

    // Wait until every queued request is taken and every result is back.
    task automatic drain();
        while (requests_taken != requests_queued || expected_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_CMP_LEN)
            model_len = data[CMP_LEN_W-1:0];
        else if (idx == REG_CODEWORD_COUNT)
            model_count = data[CODEWORD_COUNT_W-1:0];
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge clk);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Request driver: holds each request until taken, then maybe idles.
    always @(posedge clk)
    begin : drive_requests
        umi_request_t next_req;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                apply_request(presented);
                requests_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = pending_requests.pop_front();
                    presented = next_req;
                    in_valid <= 1'b1;
                    mode <= next_req.mode;
                    entry_index <= next_req.entry_index;
                    entry_bases <= next_req.entry_bases;
                    read_bases <= next_req.read_bases;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each taken result with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        umi_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_matches.size() == 0)
            begin
                report_mismatch("result with no match request pending", corrected_umi, '0);
            end
            else
            begin
                want = expected_matches.pop_front();
                if (accepted !== want.accepted)
                    report_mismatch("accepted", BASES_W'(accepted),
                                    BASES_W'(want.accepted));
                if (match_index !== want.match_index)
                    report_mismatch("match_index", BASES_W'(match_index),
                                    BASES_W'(want.match_index));
                if (corrected_umi !== want.corrected_umi)
                    report_mismatch("corrected_umi", corrected_umi, want.corrected_umi);
                if (best_distance !== want.best_distance)
                    report_mismatch("best_distance", BASES_W'(best_distance),
                                    BASES_W'(want.best_distance));
                if (runner_up_distance !== want.runner_up_distance)
                    report_mismatch("runner_up_distance", BASES_W'(runner_up_distance),
                                    BASES_W'(want.runner_up_distance));
            end
        end
        out_stall <= out_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on total run length.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(10, 64);

        // Empty whitelist right after reset: rejected, distances stay at length.
        queue_match(to_bases("ACGTACGT"));

        // Two pairs of close codewords, plus extreme slots and bases.
        queue_load(0, to_bases("ACGTACGT"));
        queue_load(1, to_bases("ACGTACGA"));
        queue_load(2, to_bases("GGGGCCCC"));
        queue_load(3, to_bases("GGGGTTTT"));
        queue_load(30, '0);
        queue_load(31, '1);
        drain();
        write_register(REG_CODEWORD_COUNT, 6'd4);

        // Exact hit, unique single error, runner-up exactly three away,
        // ambiguous double error, exact hit with a close neighbor, single error
        // between close neighbors, and reads matching nothing.
        queue_match(to_bases("GGGGCCCC"));
        queue_match(to_bases("AGGGCCCC"));
        queue_match(to_bases("GGGGTCCC"));
        queue_match(to_bases("GGGGTTCC"));
        queue_match(to_bases("ACGTACGT"));
        queue_match(to_bases("TCGTACGT"));
        queue_match(to_bases("ACGTACGA"));
        queue_match('1);
        queue_match('0);

        // Duplicate entry: the first slot wins the tie.
        queue_load(3, to_bases("GGGGCCCC"));
        queue_match(to_bases("GGGGCCCC"));
        drain();

        // Fill the rest of the whitelist, mixing in some near duplicates.
        for (int slot = 4; slot < 30; slot++)
        begin
            case ($urandom_range(9))
                0, 1, 2: queue_load(slot, with_errors(planned_words[$urandom_range(slot - 1)],
                                                      $urandom_range(2, 1), MAX_LEN));
                3: queue_load(slot, planned_words[$urandom_range(slot - 1)]);
                default: queue_load(slot, random_codeword());
            endcase
            if (slot % 3 == 0)
                queue_random_match();
        end
        drain();

        // Full length, full whitelist.
        write_register(REG_CMP_LEN, 6'd8);
        write_register(REG_CODEWORD_COUNT, 6'd32);
        queue_segment(SEGMENT_ITEMS);
        drain();

        // Shortest length with a single entry.
        write_register(REG_CMP_LEN, 6'd1);
        write_register(REG_CODEWORD_COUNT, 6'd1);
        queue_segment(SEGMENT_ITEMS);
        drain();

        // Upper data bits beyond the length field, count above the maximum.
        set_idling(64, 10);
        write_register(REG_CMP_LEN, 6'h34);
        write_register(REG_CODEWORD_COUNT, 6'd63);
        queue_segment(SEGMENT_ITEMS);
        drain();

        // Zero length counts as one.
        write_register(REG_CMP_LEN, 6'd0);
        write_register(REG_CODEWORD_COUNT, 6'd17);
        queue_segment(SEGMENT_ITEMS);
        drain();

        // Length above the maximum; long result hold-off fills the pipeline.
        set_idling(0, 0);
        write_register(REG_CMP_LEN, 6'd15);
        write_register(REG_CODEWORD_COUNT, 6'd32);
        queue_segment(SEGMENT_ITEMS);
        repeat (20) @(posedge clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
        drain();

        // A random setting to finish.
        write_register(REG_CMP_LEN, CFG_DATA_W'($urandom_range(8, 1)));
        write_register(REG_CODEWORD_COUNT, CFG_DATA_W'($urandom_range(32, 2)));
        queue_segment(SEGMENT_ITEMS);
        drain();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ umi_whitelist_matcher.f @@
+incdir+design
design/uwm_pkg.sv
design/umi_whitelist_matcher.sv
sim/tb_umi_whitelist_matcher.sv
